// ===== rtl/core/hashed_value_noise_2d_core_assert.svh =====
// assertion macros used by the checker file
`ifndef HASHED_VALUE_NOISE_2D_CORE_ASSERT_SVH
`define HASHED_VALUE_NOISE_2D_CORE_ASSERT_SVH

// clocked check, switched off while reset is high
`define HVN2_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hvn2 check failed");

// clocked check that also holds during reset
`define HVN2_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("hvn2 check failed");

`endif

// ===== rtl/core/hvn2_pkg.sv =====
`timescale 1ns / 1ps
package hvn2_pkg;

   localparam int SEED_W     = 32;
   localparam int FREQ_W     = 24;
   localparam int FRAC_W     = 16;
   localparam int HASH_W     = 32;
   localparam int VAL_W      = 16;
   localparam int CSR_DATA_W = 32;

   localparam logic [HASH_W-1:0] PRIME_X   = 32'd374761393;
   localparam logic [HASH_W-1:0] PRIME_Y   = 32'd668265263;
   localparam logic [HASH_W-1:0] PRIME_MIX = 32'd1274126177;
   localparam int                SHIFT_A   = 13;
   localparam int                SHIFT_B   = 16;

   localparam logic [SEED_W-1:0] SEED_RESET = 32'd0;
   localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd6554;

   localparam int FIFO_DEPTH  = 4;
   localparam int BACK_STAGES = 4;

   typedef enum logic [0:0] {
      CSR_NOISE_SEED = 1'b0,
      CSR_FREQUENCY  = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/core/hvn2_req_if.sv =====
`timescale 1ns / 1ps
interface hvn2_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last_pixel;

   modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                   input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
                 output ready);
endinterface

// ===== rtl/core/hvn2_rsp_if.sv =====
`timescale 1ns / 1ps
interface hvn2_rsp_if;
   import hvn2_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] noise_value;
   logic             last_out;

   modport source (output valid, output noise_value, output last_out, input ready);
   modport sink (input valid, input noise_value, input last_out, output ready);
endinterface

// ===== rtl/core/hvn2_front.sv =====
`timescale 1ns / 1ps
module hvn2_front #(
   parameter int COORD_BITS = 12,
   parameter int ENTRY_W    = 2 * (COORD_BITS + 8) + 33
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hvn2_pkg::FREQ_W-1:0] frequency,
   hvn2_req_if.sink                    req_chan,
   output logic                        push_valid,
   input  logic                        push_ready,
   output logic [ENTRY_W-1:0]          push_data
);
   import hvn2_pkg::*;

   localparam int PROD_W = COORD_BITS + FREQ_W;

   logic              valid_ff, valid_in;
   logic [PROD_W-1:0] px_ff, px_in;
   logic [PROD_W-1:0] py_ff, py_in;
   logic              last_ff, last_in;
   logic              accept;

   assign req_chan.ready = !valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign push_valid     = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      last_in  = last_ff;
      if (accept) begin
         valid_in = 1'b1;
         px_in    = PROD_W'(req_chan.pixel_x) * PROD_W'(frequency);
         py_in    = PROD_W'(req_chan.pixel_y) * PROD_W'(frequency);
         last_in  = req_chan.last_pixel;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
   end

   // cell index above the fraction, fraction below it, last flag in the lowest bit
   assign push_data = {px_ff[PROD_W-1:FRAC_W], py_ff[PROD_W-1:FRAC_W],
                       px_ff[FRAC_W-1:0], py_ff[FRAC_W-1:0], last_ff};

endmodule

// ===== rtl/core/hvn2_fifo.sv =====
`timescale 1ns / 1ps
module hvn2_fifo #(
   parameter int WIDTH = 73
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import hvn2_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [WIDTH-1:0] mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/hvn2_back.sv =====
`timescale 1ns / 1ps
module hvn2_back #(
   parameter int COORD_BITS = 12,
   parameter int ENTRY_W    = 2 * (COORD_BITS + 8) + 33
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hvn2_pkg::SEED_W-1:0] noise_seed,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  logic [ENTRY_W-1:0]          pop_data,
   hvn2_rsp_if.source                  rsp_chan
);
   import hvn2_pkg::*;

   localparam int CELL_W = COORD_BITS + FREQ_W - FRAC_W;

   logic                  en;
   logic [CELL_W-1:0]     ix, iy;
   logic [FRAC_W-1:0]     fx, fy;
   logic                  last_w;
   logic [HASH_W-1:0]     cx0, cx1, cy0, cy1;

   // stage 1: lattice products
   logic                  s1_valid_ff;
   logic [HASH_W-1:0]     mx0_ff, mx1_ff, my0_ff, my1_ff;
   logic [FRAC_W-1:0]     s1_fx_ff, s1_fy_ff;
   logic                  s1_last_ff;

   // stage 2: mixed corner hashes
   logic                  s2_valid_ff;
   logic [HASH_W-1:0]     hm_ff [4];
   logic [HASH_W-1:0]     hm_in [4];
   logic [FRAC_W-1:0]     s2_fx_ff, s2_fy_ff;
   logic                  s2_last_ff;

   // stage 3: horizontal blends
   logic                  s3_valid_ff;
   logic signed [34:0]    a_ff, b_ff, a_in, b_in;
   logic [FRAC_W-1:0]     s3_fy_ff;
   logic                  s3_last_ff;
   logic [VAL_W-1:0]      v [4];
   logic signed [17:0]    d_top, d_bot;
   logic signed [16:0]    fx_s;

   // stage 4: vertical blend into the output word
   logic                  out_valid_ff;
   logic [VAL_W-1:0]      noise_ff, noise_in;
   logic                  out_last_ff;
   logic signed [35:0]    d_ab;
   logic signed [16:0]    fy_s;
   logic signed [51:0]    r_full;

   assign en        = !out_valid_ff || rsp_chan.ready;
   assign pop_ready = en;

   assign {ix, iy, fx, fy, last_w} = pop_data;
   assign cx0 = HASH_W'(ix);
   assign cy0 = HASH_W'(iy);
   assign cx1 = cx0 + 1'b1;
   assign cy1 = cy0 + 1'b1;

   // corner order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
   always_comb begin
      logic [HASH_W-1:0] h [4];
      logic [HASH_W-1:0] t [4];
      h[0] = noise_seed ^ mx0_ff ^ my0_ff;
      h[1] = noise_seed ^ mx1_ff ^ my0_ff;
      h[2] = noise_seed ^ mx0_ff ^ my1_ff;
      h[3] = noise_seed ^ mx1_ff ^ my1_ff;
      for (int i = 0; i < 4; i++) begin
         t[i]     = h[i] ^ (h[i] >> SHIFT_A);
         hm_in[i] = t[i] * PRIME_MIX;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         v[i] = VAL_W'(hm_ff[i] ^ (hm_ff[i] >> SHIFT_B));
      end
      fx_s  = $signed({1'b0, s2_fx_ff});
      d_top = $signed({2'b00, v[1]}) - $signed({2'b00, v[0]});
      d_bot = $signed({2'b00, v[3]}) - $signed({2'b00, v[2]});
      a_in  = $signed({3'b000, v[0], 16'h0000}) + d_top * fx_s;
      b_in  = $signed({3'b000, v[2], 16'h0000}) + d_bot * fx_s;
   end

   always_comb begin
      fy_s     = $signed({1'b0, s3_fy_ff});
      d_ab     = 36'(b_ff) - 36'(a_ff);
      r_full   = $signed({a_ff[34], a_ff, 16'h0000}) + d_ab * fy_s;
      noise_in = r_full[47:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx0_ff      <= cx0 * PRIME_X;
         mx1_ff      <= cx1 * PRIME_X;
         my0_ff      <= cy0 * PRIME_Y;
         my1_ff      <= cy1 * PRIME_Y;
         s1_fx_ff    <= fx;
         s1_fy_ff    <= fy;
         s1_last_ff  <= last_w;
         hm_ff       <= hm_in;
         s2_fx_ff    <= s1_fx_ff;
         s2_fy_ff    <= s1_fy_ff;
         s2_last_ff  <= s1_last_ff;
         a_ff        <= a_in;
         b_ff        <= b_in;
         s3_fy_ff    <= s2_fy_ff;
         s3_last_ff  <= s2_last_ff;
         noise_ff    <= noise_in;
         out_last_ff <= s3_last_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.noise_value = noise_ff;
   assign rsp_chan.last_out    = out_last_ff;

endmodule

// ===== rtl/core/hashed_value_noise_2d_core.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake        word
// req_chan  in   valid / ready    pixel_x, pixel_y, last_pixel
// rsp_chan  out  valid / ready    noise_value, last_out
// csr_*     in   csr_we only      csr_index, csr_wdata
//
// one pixel per cycle sustained while rsp_chan is ready; each result passes
// through the scale register, the queue and four back stages
// a 4-word queue between scaling and hashing absorbs output stalls
// synchronous reset clears all valid flags and sets seed 0, frequency 6554
// while rsp_chan stalls, the back stages hold and req_chan fills the queue
module hashed_value_noise_2d_core #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   hvn2_req_if.sink                        req_chan,
   hvn2_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  hvn2_pkg::csr_index_type         csr_index,
   input  logic [hvn2_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hvn2_pkg::*;

   localparam int ENTRY_W = 2 * (COORD_BITS + FREQ_W - FRAC_W) + 2 * FRAC_W + 1;

   logic [SEED_W-1:0]  seed_ff, seed_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   always_comb begin
      seed_in = seed_ff;
      freq_in = freq_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NOISE_SEED: seed_in = SEED_W'(csr_wdata);
            CSR_FREQUENCY:  freq_in = csr_wdata[FREQ_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
         freq_ff <= FREQ_RESET;
      end else begin
         seed_ff <= seed_in;
         freq_ff <= freq_in;
      end
   end

   hvn2_front #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .frequency  (freq_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   hvn2_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hvn2_back #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .noise_seed (seed_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/core/hvn2_checker.sv =====
`timescale 1ns / 1ps
`include "hashed_value_noise_2d_core_assert.svh"
module hvn2_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [hvn2_pkg::VAL_W-1:0] rsp_noise,
   input logic                       rsp_last
);
   import hvn2_pkg::*;

   // words the block can hold: scale register, queue, back stages
   localparam int CAP   = 1 + FIFO_DEPTH + BACK_STAGES;
   localparam int CNT_W = $clog2(CAP + 1);

   logic [CNT_W-1:0] pend_ff, pend_in;
   logic             req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `HVN2_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_noise) && $stable(rsp_last))
   `HVN2_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)
   `HVN2_ASSERT(a_no_invented, clock, reset, rsp_valid |-> pend_ff != '0)
   `HVN2_ASSERT(a_capacity, clock, reset, pend_ff <= CNT_W'(CAP))
   `HVN2_ASSERT(a_empty_ready, clock, reset, pend_ff == '0 |-> req_ready)

endmodule

bind hashed_value_noise_2d_core hvn2_checker u_hvn2_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_noise (rsp_chan.noise_value),
   .rsp_last  (rsp_chan.last_out)
);
